// ===== design/pcirgb_pkg.sv =====
package pcirgb_pkg;

    localparam int unsigned PIX_W  = 32;
    localparam int unsigned COMP_W = 8;
    localparam int unsigned PROD_W = 2 * COMP_W;
    localparam int unsigned OUT_W  = 16;
    localparam int unsigned CFG_W  = 2;

    typedef logic [1:0] t_model;
    typedef logic [1:0] t_bits_log2;

    localparam t_model MODEL_GRAY = 2'd0;
    localparam t_model MODEL_RGB  = 2'd1;
    localparam t_model MODEL_CMYK = 2'd2;

    localparam t_model     MODEL_RESET = MODEL_CMYK;
    localparam t_bits_log2 BITS_RESET  = 2'd0;

    typedef logic t_cfg_index;
    localparam t_cfg_index CFG_COLOR_MODEL = 1'b0;
    localparam t_cfg_index CFG_BITS_LOG2   = 1'b1;

    // stage 1 result: two factors per colour whose product divided by the mask
    // gives the component value
    typedef struct packed {
        logic [COMP_W-1:0] a_r;
        logic [COMP_W-1:0] a_g;
        logic [COMP_W-1:0] a_b;
        logic [COMP_W-1:0] w;
        t_bits_log2        bits_log2;
    } t_fact;

    typedef struct packed {
        logic [PROD_W-1:0] p_r;
        logic [PROD_W-1:0] p_g;
        logic [PROD_W-1:0] p_b;
        t_bits_log2        bits_log2;
    } t_prod;

    typedef struct packed {
        logic [COMP_W-1:0] q_r;
        logic [COMP_W-1:0] q_g;
        logic [COMP_W-1:0] q_b;
        t_bits_log2        bits_log2;
    } t_quot;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_rgb;

    function automatic logic [COMP_W-1:0] mask_of(input t_bits_log2 bl2);
        logic [COMP_W-1:0] m;
        case (bl2)
            2'd0:    m = 8'h01;
            2'd1:    m = 8'h03;
            2'd2:    m = 8'h0F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    // 65535 / mask, exact for every component width
    function automatic logic [OUT_W-1:0] scale_of(input t_bits_log2 bl2);
        logic [OUT_W-1:0] s;
        case (bl2)
            2'd0:    s = 16'd65535;
            2'd1:    s = 16'd21845;
            2'd2:    s = 16'd4369;
            default: s = 16'd257;
        endcase
        return s;
    endfunction

    function automatic logic [COMP_W-1:0] comp_field(
        input logic [PIX_W-1:0] px,
        input t_bits_log2       bl2,
        input logic [1:0]       idx
    );
        logic [4:0]       amt;
        logic [PIX_W-1:0] sh;
        amt = 5'(idx) << bl2;
        sh  = px >> amt;
        return sh[COMP_W-1:0] & mask_of(bl2);
    endfunction

endpackage

// ===== design/pcirgb_pix_if.sv =====
interface pcirgb_pix_if;
    import pcirgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== design/pcirgb_rgb_if.sv =====
interface pcirgb_rgb_if;
    import pcirgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== design/packed_color_index_to_rgb16.sv =====
// Packed pixel to 16-bit RGB decoder. Each request on i_pix carries one packed pixel
// (gray, R G B or C M Y K, last component in the low bits) and yields exactly one
// request on o_rgb with 16-bit red, green and blue. The colour model and the
// component width are set through the write port and are meant to be changed only
// while the pipeline is empty. The datapath is four register stages (unpack,
// multiply, divide by the mask, scale to 16 bits), and one pixel is accepted every
// clock as long as o_rgb is ready; each stage holds its item under back-pressure
// and fills its bubbles.
module packed_color_index_to_rgb16
    import pcirgb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_cfg_index         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    pcirgb_pix_if.sink         i_pix,
    pcirgb_rgb_if.source       o_rgb
);

    t_model     r_color_model;
    t_bits_log2 r_bits_log2;

    logic  fact_valid, fact_ready;
    t_fact fact_data;
    logic  quot_valid, quot_ready;
    t_quot quot_data;
    t_rgb  rgb_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_model <= MODEL_RESET;
            r_bits_log2   <= BITS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLOR_MODEL: r_color_model <= i_cfg_data;
                CFG_BITS_LOG2:   r_bits_log2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pcirgb_unpack u_unpack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_color_model (r_color_model),
        .i_bits_log2   (r_bits_log2),
        .i_valid       (i_pix.valid),
        .o_ready       (i_pix.ready),
        .i_pixel_value (i_pix.pixel_value),
        .o_valid       (fact_valid),
        .i_ready       (fact_ready),
        .o_data        (fact_data)
    );

    pcirgb_mul_div u_mul_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fact_valid),
        .o_ready (fact_ready),
        .i_data  (fact_data),
        .o_valid (quot_valid),
        .i_ready (quot_ready),
        .o_data  (quot_data)
    );

    pcirgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (quot_valid),
        .o_ready (quot_ready),
        .i_data  (quot_data),
        .o_valid (o_rgb.valid),
        .i_ready (o_rgb.ready),
        .o_data  (rgb_data)
    );

    assign o_rgb.red   = rgb_data.red;
    assign o_rgb.green = rgb_data.green;
    assign o_rgb.blue  = rgb_data.blue;

endmodule

// ===== design/pcirgb_unpack.sv =====
module pcirgb_unpack
    import pcirgb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_model           i_color_model,
    input  t_bits_log2       i_bits_log2,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel_value,
    output logic             o_valid,
    input  logic             i_ready,
    output t_fact            o_data
);

    logic              r_valid;
    t_fact             r_data;
    t_fact             n_data;
    logic [COMP_W-1:0] mask;
    logic [COMP_W-1:0] c0, c1, c2, c3;
    logic [COMP_W-1:0] gray;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        mask = mask_of(i_bits_log2);
        c0   = comp_field(i_pixel_value, i_bits_log2, 2'd0);
        c1   = comp_field(i_pixel_value, i_bits_log2, 2'd1);
        c2   = comp_field(i_pixel_value, i_bits_log2, 2'd2);
        c3   = comp_field(i_pixel_value, i_bits_log2, 2'd3);
        // one-bit gray is inverted: set bit is black
        gray = (i_bits_log2 == 2'd0) ? {{(COMP_W-1){1'b0}}, ~c0[0]} : c0;

        n_data.bits_log2 = i_bits_log2;
        unique case (i_color_model)
            MODEL_GRAY: begin
                n_data.a_r = gray;
                n_data.a_g = gray;
                n_data.a_b = gray;
                n_data.w   = mask;
            end
            MODEL_RGB: begin
                n_data.a_r = c2;
                n_data.a_g = c1;
                n_data.a_b = c0;
                n_data.w   = mask;
            end
            MODEL_CMYK: begin
                n_data.a_r = mask - c3;
                n_data.a_g = mask - c2;
                n_data.a_b = mask - c1;
                n_data.w   = mask - c0;
            end
            default: begin
                n_data.a_r = '0;
                n_data.a_g = '0;
                n_data.a_b = '0;
                n_data.w   = mask;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/pcirgb_mul_div.sv =====
module pcirgb_mul_div
    import pcirgb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_fact i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_quot o_data
);

    logic  r_prod_valid;
    t_prod r_prod;
    t_prod n_prod;
    logic  prod_ready;
    logic  r_quot_valid;
    t_quot r_quot;
    t_quot n_quot;

    assign o_ready    = !r_prod_valid || prod_ready;
    assign prod_ready = !r_quot_valid || i_ready;

    always_comb begin
        n_prod.p_r       = PROD_W'(i_data.a_r) * PROD_W'(i_data.w);
        n_prod.p_g       = PROD_W'(i_data.a_g) * PROD_W'(i_data.w);
        n_prod.p_b       = PROD_W'(i_data.a_b) * PROD_W'(i_data.w);
        n_prod.bits_log2 = i_data.bits_log2;
    end

    // x / (2^b - 1) for x up to the squared mask: (x + (x >> b) + 1) >> b
    function automatic logic [COMP_W-1:0] div_mask(
        input logic [PROD_W-1:0] x,
        input t_bits_log2        bl2
    );
        logic [3:0]        b;
        logic [PROD_W:0]   s;
        logic [PROD_W:0]   q;
        b = 4'd1 << bl2;
        s = {1'b0, x} + {1'b0, x >> b} + (PROD_W+1)'(1);
        q = s >> b;
        return q[COMP_W-1:0];
    endfunction

    always_comb begin
        n_quot.q_r       = div_mask(r_prod.p_r, r_prod.bits_log2);
        n_quot.q_g       = div_mask(r_prod.p_g, r_prod.bits_log2);
        n_quot.q_b       = div_mask(r_prod.p_b, r_prod.bits_log2);
        n_quot.bits_log2 = r_prod.bits_log2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_quot_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_prod_valid <= i_valid;
            end
            if (prod_ready) begin
                r_quot_valid <= r_prod_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
        if (prod_ready && r_prod_valid) begin
            r_quot <= n_quot;
        end
    end

    assign o_valid = r_quot_valid;
    assign o_data  = r_quot;

endmodule

// ===== design/pcirgb_scale.sv =====
module pcirgb_scale
    import pcirgb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_quot i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_rgb  o_data
);

    localparam int unsigned SCL_W = COMP_W + OUT_W;

    logic             r_valid;
    t_rgb             r_data;
    t_rgb             n_data;
    logic [OUT_W-1:0] k;
    logic [SCL_W-1:0] s_r, s_g, s_b;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        k   = scale_of(i_data.bits_log2);
        s_r = SCL_W'(i_data.q_r) * SCL_W'(k);
        s_g = SCL_W'(i_data.q_g) * SCL_W'(k);
        s_b = SCL_W'(i_data.q_b) * SCL_W'(k);
        n_data.red   = s_r[OUT_W-1:0];
        n_data.green = s_g[OUT_W-1:0];
        n_data.blue  = s_b[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
